// ===== hdl/rc4sc_pkg.sv =====
// Shared types and constants for the RC4 stream cipher engine.
package rc4sc_pkg;

    localparam int BYTE_W      = 8;
    localparam int TBL_DEPTH   = 256;
    localparam int KEY_MAX     = 32;
    localparam int KEY_IDX_W   = $clog2(KEY_MAX);
    localparam int KLEN_W      = 6;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int KEY_WORDS   = 4;
    localparam int WORD_BYTES  = 8;

    // Command field codes.
    localparam logic CMD_REKEY = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_LENGTH = 3'd0,
        REG_KEY_0_7    = 3'd1,
        REG_KEY_8_15   = 3'd2,
        REG_KEY_16_23  = 3'd3,
        REG_KEY_24_31  = 3'd4
    } cfg_reg_t;

    // One access to the permutation table in a cycle.
    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [BYTE_W-1:0] rd_addr;
        logic              wr_en;
        logic [BYTE_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
    } tbl_req_t;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_KS_RD  = 10'b00_0000_0010,
        ST_KS_J   = 10'b00_0000_0100,
        ST_KS_WN  = 10'b00_0000_1000,
        ST_KS_WJ  = 10'b00_0001_0000,
        ST_DT_J   = 10'b00_0010_0000,
        ST_DT_SWI = 10'b00_0100_0000,
        ST_DT_SWJ = 10'b00_1000_0000,
        ST_DT_RDK = 10'b01_0000_0000,
        ST_DT_OUT = 10'b10_0000_0000
    } state_t;

endpackage

// ===== hdl/rc4sc_in_if.sv =====
// Input channel: command, data byte and last mark with a valid/ready handshake.
interface rc4sc_in_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [rc4sc_pkg::BYTE_W-1:0]  data_byte;
    logic                          last_byte;

    modport source (output valid, output command, output data_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input command, input data_byte, input last_byte,
                    output ready);
endinterface

// ===== hdl/rc4sc_out_if.sv =====
// Output channel: result byte and last mark with a valid/ready handshake.
interface rc4sc_out_if;
    logic                          valid;
    logic                          ready;
    logic [rc4sc_pkg::BYTE_W-1:0]  out_byte;
    logic                          out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== hdl/rc4sc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rc4sc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/rc4sc_table.sv =====
// Permutation table: RAM plus per-entry valid bits so unwritten entries read as identity.
module rc4sc_table (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rc4sc_pkg::tbl_req_t                  req,
    output logic [rc4sc_pkg::BYTE_W-1:0]         rd_data
);

    logic [rc4sc_pkg::TBL_DEPTH-1:0] valid_reg;
    logic [rc4sc_pkg::BYTE_W-1:0]    rd_addr_reg;
    logic                            rd_vld_reg;
    logic [rc4sc_pkg::BYTE_W-1:0]    ram_q;

    rc4sc_ram #(
        .WIDTH (rc4sc_pkg::BYTE_W),
        .DEPTH (rc4sc_pkg::TBL_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_data),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_addr_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_addr_reg <= req.rd_addr;
                rd_vld_reg  <= valid_reg[req.rd_addr];
            end
        end
    end

    // An entry never written since the last clear holds its own index.
    assign rd_data = rd_vld_reg ? ram_q : rd_addr_reg;

endmodule

// ===== hdl/rc4sc_cfg.sv =====
// Configuration registers: key length and key bytes, with key byte selection.
module rc4sc_cfg (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   write_en,
    input  logic [rc4sc_pkg::CFG_INDEX_W-1:0]      write_index,
    input  logic [rc4sc_pkg::CFG_DATA_W-1:0]       write_data,
    input  logic [rc4sc_pkg::KEY_IDX_W-1:0]        key_idx,
    output logic [rc4sc_pkg::BYTE_W-1:0]           key_byte,
    output logic [rc4sc_pkg::KLEN_W-1:0]           key_len
);

    logic [rc4sc_pkg::KLEN_W-1:0] key_length_reg;
    logic [rc4sc_pkg::KEY_WORDS-1:0][rc4sc_pkg::WORD_BYTES-1:0][rc4sc_pkg::BYTE_W-1:0] key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= rc4sc_pkg::KLEN_W'(1);
            key_reg        <= '0;
        end
        else if (write_en)
        begin
            case (write_index)
                rc4sc_pkg::REG_KEY_LENGTH: key_length_reg <= write_data[rc4sc_pkg::KLEN_W-1:0];
                rc4sc_pkg::REG_KEY_0_7:    key_reg[0]     <= write_data;
                rc4sc_pkg::REG_KEY_8_15:   key_reg[1]     <= write_data;
                rc4sc_pkg::REG_KEY_16_23:  key_reg[2]     <= write_data;
                rc4sc_pkg::REG_KEY_24_31:  key_reg[3]     <= write_data;
                default:                   ;
            endcase
        end
    end

    // A length of zero acts as one; anything above the key size saturates.
    always_comb
    begin
        if (key_length_reg == '0)
        begin
            key_len = rc4sc_pkg::KLEN_W'(1);
        end
        else if (key_length_reg > rc4sc_pkg::KLEN_W'(rc4sc_pkg::KEY_MAX))
        begin
            key_len = rc4sc_pkg::KLEN_W'(rc4sc_pkg::KEY_MAX);
        end
        else
        begin
            key_len = key_length_reg;
        end
    end

    assign key_byte = key_reg[key_idx[rc4sc_pkg::KEY_IDX_W-1:3]][key_idx[2:0]];

endmodule

// ===== hdl/rc4_stream_cipher_top.sv =====
// Top level of the RC4 stream cipher engine: sequencer, registers and table.
//
// The engine holds the 256-byte RC4 permutation in one RAM with one write and one
// read port, and every step goes through that memory one access at a time. A data
// transaction updates i and j, makes the two swap writes and reads the keystream
// byte, then loads the result register once the output side frees it, and the next
// transaction can be taken once the result is loaded. A rekey transaction runs the
// key schedule as a read, read, write, write sequence for each of the 256 swaps
// until the engine is ready again, with no result. The table starts as the identity
// permutation right after reset through per-entry valid bits, so no clearing pass
// is needed. Configuration writes must be made only while the engine is idle.
module rc4_stream_cipher_top (
    input  logic                                clk,
    input  logic                                rst_n,
    rc4sc_in_if.sink                            in_ch,
    rc4sc_out_if.source                         out_ch,
    input  logic                                write_en,
    input  logic [rc4sc_pkg::CFG_INDEX_W-1:0]   write_index,
    input  logic [rc4sc_pkg::CFG_DATA_W-1:0]    write_data
);

    rc4sc_pkg::state_t                  state_reg, state_next;
    logic [rc4sc_pkg::BYTE_W-1:0]       i_reg, i_next;
    logic [rc4sc_pkg::BYTE_W-1:0]       j_reg, j_next;
    logic [rc4sc_pkg::BYTE_W-1:0]       n_reg, n_next;
    logic [rc4sc_pkg::KEY_IDX_W-1:0]    kidx_reg, kidx_next;
    logic [rc4sc_pkg::BYTE_W-1:0]       sa_reg, sa_next;
    logic [rc4sc_pkg::BYTE_W-1:0]       sb_reg, sb_next;
    logic [rc4sc_pkg::BYTE_W-1:0]       data_reg, data_next;
    logic                               last_reg, last_next;
    logic [rc4sc_pkg::BYTE_W-1:0]       out_byte_reg, out_byte_next;
    logic                               out_last_reg, out_last_next;
    logic                               out_valid_reg, out_valid_next;

    rc4sc_pkg::tbl_req_t                tbl_req;
    logic [rc4sc_pkg::BYTE_W-1:0]       tbl_q;
    logic [rc4sc_pkg::BYTE_W-1:0]       key_byte;
    logic [rc4sc_pkg::KLEN_W-1:0]       key_len;
    logic                               accept;
    logic                               out_load;
    logic                               out_free;

    rc4sc_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data),
        .key_idx     (kidx_reg),
        .key_byte    (key_byte),
        .key_len     (key_len)
    );

    rc4sc_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tbl_req),
        .rd_data (tbl_q)
    );

    assign in_ch.ready     = (state_reg == rc4sc_pkg::ST_IDLE);
    assign accept          = in_ch.valid && in_ch.ready;
    assign out_free        = !out_valid_reg || out_ch.ready;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.out_last = out_last_reg;

    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        n_next        = n_reg;
        kidx_next     = kidx_reg;
        sa_next       = sa_reg;
        sb_next       = sb_reg;
        data_next     = data_reg;
        last_next     = last_reg;
        out_byte_next = out_byte_reg;
        out_last_next = out_last_reg;
        out_load      = 1'b0;
        tbl_req       = '0;

        case (state_reg)
            rc4sc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    data_next = in_ch.data_byte;
                    last_next = in_ch.last_byte;
                    if (in_ch.command == rc4sc_pkg::CMD_REKEY)
                    begin
                        tbl_req.clear = 1'b1;
                        n_next        = '0;
                        j_next        = '0;
                        kidx_next     = '0;
                        state_next    = rc4sc_pkg::ST_KS_RD;
                    end
                    else
                    begin
                        i_next          = i_reg + 8'd1;
                        tbl_req.rd_en   = 1'b1;
                        tbl_req.rd_addr = i_reg + 8'd1;
                        state_next      = rc4sc_pkg::ST_DT_J;
                    end
                end
            end

            rc4sc_pkg::ST_KS_RD:
            begin
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = n_reg;
                state_next      = rc4sc_pkg::ST_KS_J;
            end

            rc4sc_pkg::ST_KS_J:
            begin
                sa_next         = tbl_q;
                j_next          = j_reg + tbl_q + key_byte;
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = j_reg + tbl_q + key_byte;
                state_next      = rc4sc_pkg::ST_KS_WN;
            end

            rc4sc_pkg::ST_KS_WN:
            begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = n_reg;
                tbl_req.wr_data = tbl_q;
                state_next      = rc4sc_pkg::ST_KS_WJ;
            end

            rc4sc_pkg::ST_KS_WJ:
            begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = j_reg;
                tbl_req.wr_data = sa_reg;
                n_next          = n_reg + 8'd1;
                // The key index runs modulo the effective key length.
                if ({1'b0, kidx_reg} + rc4sc_pkg::KLEN_W'(1) == key_len)
                begin
                    kidx_next = '0;
                end
                else
                begin
                    kidx_next = kidx_reg + 5'd1;
                end
                if (n_reg == 8'hFF)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = rc4sc_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = rc4sc_pkg::ST_KS_RD;
                end
            end

            rc4sc_pkg::ST_DT_J:
            begin
                sa_next         = tbl_q;
                j_next          = j_reg + tbl_q;
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = j_reg + tbl_q;
                state_next      = rc4sc_pkg::ST_DT_SWI;
            end

            rc4sc_pkg::ST_DT_SWI:
            begin
                sb_next         = tbl_q;
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = i_reg;
                tbl_req.wr_data = tbl_q;
                state_next      = rc4sc_pkg::ST_DT_SWJ;
            end

            rc4sc_pkg::ST_DT_SWJ:
            begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = j_reg;
                tbl_req.wr_data = sa_reg;
                state_next      = rc4sc_pkg::ST_DT_RDK;
            end

            rc4sc_pkg::ST_DT_RDK:
            begin
                // After the swap S[i] holds the old S[j] and S[j] the old S[i].
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = sa_reg + sb_reg;
                state_next      = rc4sc_pkg::ST_DT_OUT;
            end

            rc4sc_pkg::ST_DT_OUT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_byte_next = data_reg ^ tbl_q;
                    out_last_next = last_reg;
                    if (last_reg)
                    begin
                        i_next = '0;
                        j_next = '0;
                    end
                    state_next = rc4sc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rc4sc_pkg::ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rc4sc_pkg::ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            kidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            kidx_reg      <= kidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_reg       <= sa_next;
        sb_reg       <= sb_next;
        data_reg     <= data_next;
        last_reg     <= last_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ===== sim/rc4_keystream_checker.sv =====
// Checker that tracks the RC4 table from observed transactions and compares every result.
`timescale 1ns / 1ps
module rc4_keystream_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    rc4sc_in_if                                  in_ch,
    rc4sc_out_if                                 out_ch,
    input  logic                                 write_en,
    input  logic [rc4sc_pkg::CFG_INDEX_W-1:0]    write_index,
    input  logic [rc4sc_pkg::CFG_DATA_W-1:0]     write_data,
    output int                                   pending_results,
    output int                                   results_checked,
    output int                                   mismatch_count
);

    typedef struct packed {
        logic [rc4sc_pkg::BYTE_W-1:0] cipher_byte;
        logic                         last_mark;
    } cipher_result_t;

    cipher_result_t    expected_ciphers[$];
    cipher_result_t    want;
    cipher_result_t    got;

    logic [rc4sc_pkg::BYTE_W-1:0]     perm [rc4sc_pkg::TBL_DEPTH];
    logic [rc4sc_pkg::BYTE_W-1:0]     pos_i;
    logic [rc4sc_pkg::BYTE_W-1:0]     pos_j;
    logic [rc4sc_pkg::KLEN_W-1:0]     key_len;
    logic [rc4sc_pkg::CFG_DATA_W-1:0] key_word [rc4sc_pkg::KEY_WORDS];
    int                               n_checked;
    int                               n_mismatch;

    function automatic logic [rc4sc_pkg::BYTE_W-1:0] key_byte(int n);
        return key_word[n / rc4sc_pkg::WORD_BYTES]
                       [(n % rc4sc_pkg::WORD_BYTES) * rc4sc_pkg::BYTE_W +: rc4sc_pkg::BYTE_W];
    endfunction

    function automatic void reset_predictor();
        for (int n = 0; n < rc4sc_pkg::TBL_DEPTH; n++)
        begin
            perm[n] = n[rc4sc_pkg::BYTE_W-1:0];
        end
        pos_i   = '0;
        pos_j   = '0;
        key_len = rc4sc_pkg::KLEN_W'(1);
        for (int w = 0; w < rc4sc_pkg::KEY_WORDS; w++)
        begin
            key_word[w] = '0;
        end
        expected_ciphers.delete();
    endfunction

    function automatic void run_key_schedule();
        int                           len;
        logic [rc4sc_pkg::BYTE_W-1:0] j;
        logic [rc4sc_pkg::BYTE_W-1:0] held;
        len = int'(key_len);
        // A zero length uses one key byte; anything past the key registers saturates.
        if (len == 0)
            len = 1;
        if (len > rc4sc_pkg::KEY_MAX)
            len = rc4sc_pkg::KEY_MAX;
        for (int n = 0; n < rc4sc_pkg::TBL_DEPTH; n++)
        begin
            perm[n] = n[rc4sc_pkg::BYTE_W-1:0];
        end
        j = '0;
        for (int n = 0; n < rc4sc_pkg::TBL_DEPTH; n++)
        begin
            j       = j + perm[n] + key_byte(n % len);
            held    = perm[n];
            perm[n] = perm[j];
            perm[j] = held;
        end
        pos_i = '0;
        pos_j = '0;
    endfunction

    function automatic logic [rc4sc_pkg::BYTE_W-1:0] next_keystream_byte();
        logic [rc4sc_pkg::BYTE_W-1:0] held;
        logic [rc4sc_pkg::BYTE_W-1:0] sum;
        pos_i       = pos_i + 1'b1;
        pos_j       = pos_j + perm[pos_i];
        held        = perm[pos_i];
        perm[pos_i] = perm[pos_j];
        perm[pos_j] = held;
        sum         = perm[pos_i] + perm[pos_j];
        return perm[sum];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_predictor();
            n_checked       = 0;
            n_mismatch      = 0;
            pending_results <= 0;
            results_checked <= 0;
            mismatch_count  <= 0;
        end
        else
        begin
            if (write_en)
            begin
                case (write_index)
                    rc4sc_pkg::REG_KEY_LENGTH: key_len = write_data[rc4sc_pkg::KLEN_W-1:0];
                    rc4sc_pkg::REG_KEY_0_7:    key_word[0] = write_data;
                    rc4sc_pkg::REG_KEY_8_15:   key_word[1] = write_data;
                    rc4sc_pkg::REG_KEY_16_23:  key_word[2] = write_data;
                    rc4sc_pkg::REG_KEY_24_31:  key_word[3] = write_data;
                    default: ;
                endcase
            end

            // Results are compared before new inputs are predicted, so a result can
            // never be matched against an expectation queued at the same edge.
            if (out_ch.valid && out_ch.ready)
            begin
                got.cipher_byte = out_ch.out_byte;
                got.last_mark   = out_ch.out_last;
                if (expected_ciphers.size() == 0)
                begin
                    n_mismatch++;
                    $display("%0t: result transaction with none expected: expected none, %s",
                             $time, "actual below");
                    $display("%0t: actual out_byte %02h out_last %0b",
                             $time, got.cipher_byte, got.last_mark);
                end
                else
                begin
                    want = expected_ciphers.pop_front();
                    n_checked++;
                    if (got.cipher_byte !== want.cipher_byte)
                    begin
                        n_mismatch++;
                        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                                 $time, want.cipher_byte, got.cipher_byte);
                    end
                    if (got.last_mark !== want.last_mark)
                    begin
                        n_mismatch++;
                        $display("%0t: out_last mismatch: expected %0b, actual %0b",
                                 $time, want.last_mark, got.last_mark);
                    end
                end
            end

            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.command == rc4sc_pkg::CMD_REKEY)
                begin
                    run_key_schedule();
                end
                else
                begin
                    want.cipher_byte = in_ch.data_byte ^ next_keystream_byte();
                    want.last_mark   = in_ch.last_byte;
                    expected_ciphers.push_back(want);
                    // The table survives the end of a message; only the indices restart.
                    if (in_ch.last_byte)
                    begin
                        pos_i = '0;
                        pos_j = '0;
                    end
                end
            end

            pending_results <= expected_ciphers.size();
            results_checked <= n_checked;
            mismatch_count  <= n_mismatch;
        end
    end

endmodule

// ===== sim/tb_rc4_stream_cipher_top.sv =====
// Testbench top for the RC4 stream cipher engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_rc4_stream_cipher_top;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 7;
    // A rekey produces no result to wait on, so the drain spans a whole key schedule.
    localparam int ENGINE_DRAIN = 1100;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int KEY_PHASES   = 10;
    localparam int LONG_PHASE   = 3;
    localparam int ZERO_PHASE   = 4;
    localparam int ONES_PHASE   = 5;

    logic                             clk   = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             write_en;
    rc4sc_pkg::cfg_reg_t              write_index;
    logic [rc4sc_pkg::CFG_DATA_W-1:0] write_data;

    int          sender_idle_pct;
    int          receiver_stall_pct;
    int unsigned cycle_count = 0;
    int          pending_results;
    int          results_checked;
    int          mismatch_count;
    int          data_sent     = 0;
    int          rekeys_sent   = 0;
    int          messages_sent = 0;
    int          key_settings  = 0;

    rc4sc_in_if  in_ch();
    rc4sc_out_if out_ch();

    rc4_stream_cipher_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data)
    );

    rc4_keystream_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .write_en        (write_en),
        .write_index     (write_index),
        .write_data      (write_data),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .mismatch_count  (mismatch_count)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge clk)
    begin
        out_ch.ready <= rst_n && ($urandom_range(99) >= receiver_stall_pct);
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d results outstanding",
                 CYCLE_LIMIT, pending_results);
        $display("== FAIL ==");
        $finish;
    end

    // Valid stays high across back-to-back transactions; it only drops while idling.
    task automatic send_item(input logic cmd, input logic [rc4sc_pkg::BYTE_W-1:0] data,
                             input logic last);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.command   <= cmd;
        in_ch.data_byte <= data;
        in_ch.last_byte <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (cmd == rc4sc_pkg::CMD_REKEY)
            rekeys_sent++;
        else
            data_sent++;
    endtask

    task automatic send_message(input int len);
        messages_sent++;
        for (int k = 0; k < len; k++)
        begin
            // Now and then a rekey cuts into the middle of a message.
            if (k != 0 && $urandom_range(99) < 2)
                send_item(rc4sc_pkg::CMD_REKEY, rc4sc_pkg::BYTE_W'($urandom), 1'($urandom));
            send_item(rc4sc_pkg::CMD_DATA, rc4sc_pkg::BYTE_W'($urandom), k == len - 1);
        end
    endtask

    task automatic wait_engine_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (ENGINE_DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(input rc4sc_pkg::cfg_reg_t idx,
                             input logic [rc4sc_pkg::CFG_DATA_W-1:0] value);
        write_en    <= 1'b1;
        write_index <= idx;
        write_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_key(input logic [rc4sc_pkg::CFG_DATA_W-1:0] len_word,
                            input logic [rc4sc_pkg::CFG_DATA_W-1:0] k0, k1, k2, k3);
        wait_engine_idle();
        write_reg(rc4sc_pkg::REG_KEY_LENGTH, len_word);
        write_reg(rc4sc_pkg::REG_KEY_0_7, k0);
        write_reg(rc4sc_pkg::REG_KEY_8_15, k1);
        write_reg(rc4sc_pkg::REG_KEY_16_23, k2);
        write_reg(rc4sc_pkg::REG_KEY_24_31, k3);
        write_en <= 1'b0;
        key_settings++;
    endtask

    task automatic pick_idling();
        case ($urandom_range(3))
            0:
            begin
                sender_idle_pct    <= 0;
                receiver_stall_pct <= 0;
            end
            1:
            begin
                sender_idle_pct    <= 57;
                receiver_stall_pct <= 0;
            end
            2:
            begin
                sender_idle_pct    <= 0;
                receiver_stall_pct <= 57;
            end
            default:
            begin
                sender_idle_pct    <= 6;
                receiver_stall_pct <= 6;
            end
        endcase
    endtask

    initial
    begin
        int                               len_pick [8];
        int                               klen;
        int                               phase_target;
        logic [rc4sc_pkg::CFG_DATA_W-1:0] len_word;
        logic [rc4sc_pkg::CFG_DATA_W-1:0] kw [rc4sc_pkg::KEY_WORDS];

        len_pick           = '{1, 32, 0, 63, 2, 16, 33, 31};
        in_ch.valid        <= 1'b0;
        in_ch.command      <= rc4sc_pkg::CMD_DATA;
        in_ch.data_byte    <= '0;
        in_ch.last_byte    <= 1'b0;
        write_en           <= 1'b0;
        write_index        <= rc4sc_pkg::REG_KEY_LENGTH;
        write_data         <= '0;
        sender_idle_pct    <= 0;
        receiver_stall_pct <= 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight out of reset the table is the identity and the key is zero.
        send_item(rc4sc_pkg::CMD_DATA, 8'h00, 1'b0);
        send_item(rc4sc_pkg::CMD_DATA, 8'hFF, 1'b0);
        send_item(rc4sc_pkg::CMD_DATA, 8'hA5, 1'b1);
        send_item(rc4sc_pkg::CMD_DATA, 8'h3C, 1'b0);
        // A last mark on a rekey changes nothing.
        send_item(rc4sc_pkg::CMD_REKEY, 8'h96, 1'b1);
        send_item(rc4sc_pkg::CMD_DATA, 8'hFF, 1'b0);
        send_item(rc4sc_pkg::CMD_DATA, 8'h00, 1'b1);

        // Zero length falls back to one key byte; the unused upper bits are set.
        load_key({{(rc4sc_pkg::CFG_DATA_W-rc4sc_pkg::KLEN_W){1'b1}},
                  {rc4sc_pkg::KLEN_W{1'b0}}}, '1, '1, '1, '1);
        send_item(rc4sc_pkg::CMD_REKEY, 8'h00, 1'b0);
        send_item(rc4sc_pkg::CMD_DATA, 8'h00, 1'b0);
        send_item(rc4sc_pkg::CMD_DATA, 8'h80, 1'b1);

        // The largest length field saturates to the full 32-byte key.
        load_key(64'd63, 64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908,
                 64'h1716_1514_1312_1110, 64'h1F1E_1D1C_1B1A_1918);
        send_item(rc4sc_pkg::CMD_REKEY, 8'h5A, 1'b0);
        send_item(rc4sc_pkg::CMD_DATA, 8'h01, 1'b0);
        send_item(rc4sc_pkg::CMD_DATA, 8'hFE, 1'b1);

        load_key(64'd32, 64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908,
                 64'h1716_1514_1312_1110, 64'h1F1E_1D1C_1B1A_1918);
        send_item(rc4sc_pkg::CMD_REKEY, 8'hC3, 1'b0);
        send_item(rc4sc_pkg::CMD_DATA, 8'h7F, 1'b0);
        send_item(rc4sc_pkg::CMD_REKEY, 8'h0F, 1'b0);
        send_item(rc4sc_pkg::CMD_DATA, 8'h55, 1'b1);

        load_key(64'd1, 64'hFF, '0, '0, '0);
        send_item(rc4sc_pkg::CMD_REKEY, 8'hF0, 1'b1);
        send_item(rc4sc_pkg::CMD_DATA, 8'hAA, 1'b1);

        for (int p = 0; p < KEY_PHASES; p++)
        begin
            klen = (p < 8) ? len_pick[p] : $urandom_range(63);
            len_word = {$urandom, $urandom};
            len_word[rc4sc_pkg::KLEN_W-1:0] = klen[rc4sc_pkg::KLEN_W-1:0];
            for (int w = 0; w < rc4sc_pkg::KEY_WORDS; w++)
            begin
                kw[w] = (p == ZERO_PHASE) ? '0 :
                        (p == ONES_PHASE) ? '1 : {$urandom, $urandom};
            end
            load_key(len_word, kw[0], kw[1], kw[2], kw[3]);
            pick_idling();
            send_item(rc4sc_pkg::CMD_REKEY, rc4sc_pkg::BYTE_W'($urandom), 1'($urandom));
            phase_target = data_sent + RANDOM_ITEMS / KEY_PHASES;
            // One long message so that i and the table sum wrap past 255.
            if (p == LONG_PHASE)
                send_message(300);
            while (data_sent < phase_target)
            begin
                pick_idling();
                if ($urandom_range(99) < 8)
                    send_item(rc4sc_pkg::CMD_REKEY, rc4sc_pkg::BYTE_W'($urandom),
                              1'($urandom));
                send_message(($urandom_range(99) < 4) ? $urandom_range(13, 80)
                                                      : $urandom_range(1, 12));
            end
        end

        sender_idle_pct    <= 0;
        receiver_stall_pct <= 0;
        wait_engine_idle();

        $display("Sent %0d data bytes in %0d messages and %0d rekeys under %0d key settings.",
                 data_sent, messages_sent, rekeys_sent, key_settings);
        $display("Compared %0d result transactions; %0d mismatches found.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== rc4_stream_cipher_top.f =====
hdl/rc4sc_pkg.sv
hdl/rc4sc_in_if.sv
hdl/rc4sc_out_if.sv
hdl/rc4sc_ram.sv
hdl/rc4sc_table.sv
hdl/rc4sc_cfg.sv
hdl/rc4_stream_cipher_top.sv
sim/rc4_keystream_checker.sv
sim/tb_rc4_stream_cipher_top.sv
